>>> sv/q24fx_pkg.sv
// shared types, opcodes and helpers for the q24.8 fixed-point alu
`timescale 1ns / 1ps
`default_nettype none
package q24fx_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_W        = 32;
  localparam int QUOT_W        = 48;   // dividend width at the largest fraction size
  localparam int PROD_W        = 64;
  localparam int MAG_W         = 65;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_EQ   = 4'd4,
    OP_NE   = 4'd5,
    OP_GE   = 4'd6,
    OP_LE   = 4'd7,
    OP_GT   = 4'd8,
    OP_LT   = 4'd9,
    OP_MIN  = 4'd10,
    OP_MAX  = 4'd11,
    OP_INC  = 4'd12,
    OP_DEC  = 4'd13,
    OP_FINT = 4'd14,
    OP_TINT = 4'd15
  } opcode_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DBZ = 2'd2;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

  typedef struct packed {
    logic [3:0]               opcode;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     compare_true;
    logic [1:0]               status;
  } out_word_t;

  // one pipeline stage of the chain
  typedef struct packed {
    opcode_t                  op;
    logic signed [WORD_W-1:0] res;
    logic                     cmp;
    logic [1:0]               status;
    logic                     neg;
    logic                     bz;
    logic [WORD_W-1:0]        den;
    logic [WORD_W-1:0]        rem;
    logic [QUOT_W-1:0]        num;
    logic [PROD_W-1:0]        prod;
  } stg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     flag;
  } sat_t;

  function automatic sat_t apply_sign(input logic [MAG_W-1:0] mag, input logic neg);
    sat_t r;
    r.flag = 1'b0;
    if (neg) begin
      if (mag > MAG_W'(33'h080000000)) begin
        r.value = WORD_MIN;
        r.flag  = 1'b1;
      end else begin
        r.value = signed'(~mag[WORD_W-1:0] + 32'd1);
      end
    end else begin
      if (mag > MAG_W'(33'h07fffffff)) begin
        r.value = WORD_MAX;
        r.flag  = 1'b1;
      end else begin
        r.value = signed'(mag[WORD_W-1:0]);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/q24fx_front.sv
// entry stage: simple operations, product and divider set-up
`timescale 1ns / 1ps
`default_nettype none
module q24fx_front import q24fx_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     valid_i,
  input  wire in_word_t word_i,
  output logic          valid_o,
  output stg_t          stg_o
);

  logic                     valid_r;
  stg_t                     stg_r, stg_nxt;
  logic signed [WORD_W-1:0] a, b;
  logic signed [WORD_W:0]   s33;
  logic signed [QUOT_W-1:0] fx;
  logic [WORD_W-1:0]        mag_a, mag_b;

  assign a     = word_i.operand_a;
  assign b     = word_i.operand_b;
  assign mag_a = a[WORD_W-1] ? (~a + 32'd1) : a;
  assign mag_b = b[WORD_W-1] ? (~b + 32'd1) : b;
  assign fx    = QUOT_W'(a) <<< FRACTION_BITS;

  always_comb begin
    stg_nxt        = '0;
    stg_nxt.op     = opcode_t'(word_i.opcode);
    stg_nxt.neg    = a[WORD_W-1] ^ b[WORD_W-1];
    stg_nxt.bz     = (b == '0);
    stg_nxt.den    = mag_b;
    stg_nxt.num    = {mag_a, {(QUOT_W-WORD_W){1'b0}}};
    stg_nxt.prod   = PROD_W'(mag_a) * PROD_W'(mag_b);
    s33            = '0;
    case (stg_nxt.op)
      OP_ADD:  s33 = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      OP_SUB:  s33 = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      OP_INC:  s33 = {a[WORD_W-1], a} + 33'sd1;
      OP_DEC:  s33 = {a[WORD_W-1], a} - 33'sd1;
      default: s33 = '0;
    endcase
    case (stg_nxt.op)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (s33[WORD_W] != s33[WORD_W-1]) begin
          stg_nxt.res    = s33[WORD_W] ? WORD_MIN : WORD_MAX;
          stg_nxt.status = ST_SAT;
        end else begin
          stg_nxt.res = s33[WORD_W-1:0];
        end
      end
      OP_FINT: begin
        if (fx[QUOT_W-1:WORD_W-1] != {(QUOT_W-WORD_W+1){fx[QUOT_W-1]}}) begin
          stg_nxt.res    = fx[QUOT_W-1] ? WORD_MIN : WORD_MAX;
          stg_nxt.status = ST_SAT;
        end else begin
          stg_nxt.res = fx[WORD_W-1:0];
        end
      end
      OP_TINT: stg_nxt.res = a >>> FRACTION_BITS;
      OP_MIN:  stg_nxt.res = (a > b) ? b : a;
      OP_MAX:  stg_nxt.res = (b > a) ? b : a;
      OP_EQ:   stg_nxt.cmp = (a == b);
      OP_NE:   stg_nxt.cmp = (a != b);
      OP_GE:   stg_nxt.cmp = (a >= b);
      OP_LE:   stg_nxt.cmp = (a <= b);
      OP_GT:   stg_nxt.cmp = (a > b);
      OP_LT:   stg_nxt.cmp = (a < b);
      default: stg_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stg_o   = stg_r;

endmodule
`default_nettype wire

>>> sv/q24fx_div_cell.sv
// one restoring-divide cell: one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module q24fx_div_cell import q24fx_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic valid_i,
  input  wire stg_t stg_i,
  output logic      valid_o,
  output stg_t      stg_o
);

  logic          valid_r;
  stg_t          stg_r, stg_nxt;
  logic [WORD_W:0] rem_sh, rem_sub;
  logic          ge;

  always_comb begin
    rem_sh  = {stg_i.rem, stg_i.num[QUOT_W-1]};
    rem_sub = rem_sh - {1'b0, stg_i.den};
    ge      = (rem_sh >= {1'b0, stg_i.den});
    stg_nxt     = stg_i;
    stg_nxt.rem = ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
    stg_nxt.num = {stg_i.num[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stg_o   = stg_r;

endmodule
`default_nettype wire

>>> sv/q24fx_back.sv
// exit stage: rounding and saturation of multiply and divide, output register
`timescale 1ns / 1ps
`default_nettype none
module q24fx_back import q24fx_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic valid_i,
  input  wire stg_t stg_i,
  output logic      valid_o,
  output out_word_t word_o
);

  logic      valid_r;
  out_word_t word_r, word_nxt;
  logic [MAG_W-1:0] mmag, dmag;
  logic      up;
  sat_t      ms, ds;

  always_comb begin
    mmag = (MAG_W'(stg_i.prod) + (MAG_W'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    up   = ({stg_i.rem, 1'b0} >= {1'b0, stg_i.den});
    dmag = MAG_W'(stg_i.num) + MAG_W'(up);
    ms   = apply_sign(mmag, stg_i.neg);
    ds   = apply_sign(dmag, stg_i.neg);
    word_nxt.result_value = stg_i.res;
    word_nxt.compare_true = stg_i.cmp;
    word_nxt.status       = stg_i.status;
    case (stg_i.op)
      OP_MUL: begin
        word_nxt.result_value = ms.value;
        word_nxt.status       = ms.flag ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (stg_i.bz) begin
          word_nxt.result_value = '0;
          word_nxt.status       = ST_DBZ;
        end else begin
          word_nxt.result_value = ds.value;
          word_nxt.status       = ds.flag ? ST_SAT : ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule
`default_nettype wire

>>> sv/q24_8_fixed_point_alu_core.sv
// top level of the signed fixed-point alu
// Signed Q24.8 fixed-point ALU (FRACTION_BITS fraction bits, 1 to 16). One word enters per
// clock and one result word leaves for each. Every operation goes through the same pipeline
// of 32+FRACTION_BITS+2 stages (42 at Q24.8): an entry stage with the 32x32 multiplier, one
// restoring-divide cell per quotient bit, and a rounding and output stage. Latency is set by
// the divide cell chain. The pipeline moves as a whole and holds while a finished result is
// stalled; in_stall follows out_stall in the same cycle when the output word is waiting.
`timescale 1ns / 1ps
`default_nettype none
module q24_8_fixed_point_alu_core import q24fx_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  localparam int NCELL = WORD_W + FRACTION_BITS;

  logic         adv;
  logic [NCELL:0] v;
  stg_t         s [NCELL+1];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  q24fx_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .valid_i(in_valid), .word_i(in_word),
    .valid_o(v[0]), .stg_o(s[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    q24fx_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .valid_i(v[i]), .stg_i(s[i]),
      .valid_o(v[i+1]), .stg_o(s[i+1])
    );
  end

  q24fx_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .valid_i(v[NCELL]), .stg_i(s[NCELL]),
    .valid_o(out_valid), .word_o(out_word)
  );

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status != 2'd3)
    else $error("bad status code");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.compare_true) |-> (out_word.result_value == '0 &&
      out_word.status == ST_OK))
    else $error("compare result not clean");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall out of step with output");

endmodule
`default_nettype wire
